@@ design/ssfw_pkg.sv @@
// ssfw_pkg: shared constants, phase codes and segment table for the
// seven-segment frame writer; no dependencies

package ssfw_pkg;

  // display driver command bytes
  localparam logic [7:0] CMD_AUTO_ADDR  = 8'h40;
  localparam logic [7:0] CMD_START_ADDR = 8'hC0;
  localparam logic [7:0] CMD_DISPLAY_ON = 8'h8F;

  // reciprocal constants for digit extraction by multiply and shift
  localparam logic [16:0] RECIP_1000   = 17'd67109;  // v * k >> 26 == v / 1000
  localparam int unsigned SHIFT_1000   = 26;
  localparam logic [7:0]  RECIP_10     = 8'd205;     // x * k >> 11 == x / 10
  localparam int unsigned SHIFT_10     = 11;
  localparam logic [5:0]  RECIP_100    = 6'd41;      // x * k >> 12 == x / 100
  localparam int unsigned SHIFT_100    = 12;

  // phase codes, one per frame byte
  localparam int unsigned PhaseW = 3;
  localparam logic [PhaseW-1:0] PH_AUTO  = 3'd0;
  localparam logic [PhaseW-1:0] PH_START = 3'd1;
  localparam logic [PhaseW-1:0] PH_THOU  = 3'd2;
  localparam logic [PhaseW-1:0] PH_HUND  = 3'd3;
  localparam logic [PhaseW-1:0] PH_TENS  = 3'd4;
  localparam logic [PhaseW-1:0] PH_UNITS = 3'd5;
  localparam logic [PhaseW-1:0] PH_DISP  = 3'd6;

  // common-cathode segment pattern, bit 0 = segment a, dot always off
  function automatic logic [7:0] seg_of(input logic [3:0] digit);
    logic [7:0] seg;
    case (digit)
      4'd0:    seg = 8'h3F;
      4'd1:    seg = 8'h06;
      4'd2:    seg = 8'h5B;
      4'd3:    seg = 8'h4F;
      4'd4:    seg = 8'h66;
      4'd5:    seg = 8'h6D;
      4'd6:    seg = 8'h7D;
      4'd7:    seg = 8'h07;
      4'd8:    seg = 8'h7F;
      4'd9:    seg = 8'h6F;
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

endpackage

@@ design/seven_segment_frame_writer_top.sv @@
// seven_segment_frame_writer_top: converts a 16-bit count into the seven
// byte frame sequence for a four-digit display driver; uses ssfw_pkg
//
// The first byte of an update passes the phase register, then the output register.
// Throughput: one byte per cycle; the next start is taken while the sequencer
// is in its display-on phase, so updates can follow one another without a gap.
// Reset: asynchronous, active low; clears the sequencer and the strobe.
// The receiver cannot stall: each byte is valid for exactly one cycle.

module seven_segment_frame_writer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] count_value_i,
  output logic        valid_o,
  output logic [7:0]  wire_byte_o,
  output logic        start_before_o,
  output logic        stop_after_o,
  output logic        last_of_update_o
);
  import ssfw_pkg::*;

  logic              accept;
  logic              active_q, active_d;
  logic [PhaseW-1:0] phase_q, phase_d;
  logic [15:0]       value_q;

  // digit datapath registers
  logic [6:0]        thsd_q;     // value / 1000, 0..65
  logic [3:0]        thou_q;
  logic [9:0]        rem_q;      // value mod 1000
  logic [3:0]        hund_q;
  logic [6:0]        rem2_q;     // value mod 100
  logic [3:0]        tens_q;

  logic [32:0]       prod_thsd;
  logic [14:0]       prod_thou;
  logic [3:0]        thou_quot;
  logic [15:0]       thsd_scaled;
  logic [15:0]       prod_hund;
  logic [6:0]        hund_scaled;
  logic [14:0]       prod_tens;
  logic [3:0]        tens_d;
  logic [3:0]        units_d;

  logic [7:0]        byte_d;
  logic              sb_d, sa_d, last_d;

  // transaction accept and sequencer
  assign accept = start && !busy;
  assign busy   = active_q && (phase_q != PH_DISP);

  always_comb begin
    active_d = active_q;
    phase_d  = phase_q;
    if (accept) begin
      active_d = 1'b1;
      phase_d  = PH_AUTO;
    end else if (active_q) begin
      if (phase_q == PH_DISP) begin
        active_d = 1'b0;
      end else begin
        phase_d = phase_q + PhaseW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      phase_q  <= PH_AUTO;
      valid_o  <= 1'b0;
    end else begin
      active_q <= active_d;
      phase_q  <= phase_d;
      valid_o  <= active_q;
    end
  end

  // digit arithmetic by reciprocal multiply and shift, spread over the phases
  assign prod_thsd   = 33'(value_q) * 33'(RECIP_1000);
  assign prod_thou   = 15'(thsd_q) * 15'(RECIP_10);
  assign thou_quot   = prod_thou[SHIFT_10 +: 4];
  assign thsd_scaled = 16'(thsd_q) * 16'd1000;
  assign prod_hund   = 16'(rem_q) * 16'(RECIP_100);
  assign hund_scaled = 7'(rem_q - 10'(hund_q) * 10'd100);
  assign prod_tens   = 15'(rem2_q) * 15'(RECIP_10);
  assign tens_d      = prod_tens[SHIFT_10 +: 4];
  assign units_d     = 4'(rem2_q - 7'(tens_q) * 7'd10);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      value_q <= count_value_i;
    end
    if (active_q) begin
      case (phase_q)
        PH_AUTO: begin
          thsd_q <= prod_thsd[SHIFT_1000 +: 7];
        end
        PH_START: begin
          thou_q <= 4'(thsd_q - 7'(thou_quot) * 7'd10);
          rem_q  <= 10'(value_q - thsd_scaled);
        end
        PH_THOU: begin
          hund_q <= prod_hund[SHIFT_100 +: 4];
        end
        PH_HUND: begin
          rem2_q <= hund_scaled;
        end
        PH_TENS: begin
          tens_q <= tens_d;
        end
        default: begin
        end
      endcase
    end
  end

  // frame byte selection per phase
  always_comb begin
    byte_d = CMD_AUTO_ADDR;
    sb_d   = 1'b0;
    sa_d   = 1'b0;
    last_d = 1'b0;
    unique case (phase_q)
      PH_AUTO: begin
        byte_d = CMD_AUTO_ADDR;
        sb_d   = 1'b1;
        sa_d   = 1'b1;
      end
      PH_START: begin
        byte_d = CMD_START_ADDR;
        sb_d   = 1'b1;
      end
      PH_THOU:  byte_d = seg_of(thou_q);
      PH_HUND:  byte_d = seg_of(hund_q);
      PH_TENS:  byte_d = seg_of(tens_d);
      PH_UNITS: begin
        byte_d = seg_of(units_d);
        sa_d   = 1'b1;
      end
      PH_DISP: begin
        byte_d = CMD_DISPLAY_ON;
        sb_d   = 1'b1;
        sa_d   = 1'b1;
        last_d = 1'b1;
      end
      default: begin
        byte_d = CMD_AUTO_ADDR;
      end
    endcase
  end

  // result register
  always_ff @(posedge clk_i) begin
    wire_byte_o      <= byte_d;
    start_before_o   <= sb_d;
    stop_after_o     <= sa_d;
    last_of_update_o <= last_d;
  end

  // an accepted count opens its frame sequence with the auto-address command
  a_first_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ##1 (valid_o && wire_byte_o == CMD_AUTO_ADDR))
    else $error("update did not open with auto-address command");

  // bytes of one update come without gaps
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !last_of_update_o) |=> valid_o)
    else $error("gap inside an update");

  // after the closing byte only a new update may follow
  a_next_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && last_of_update_o) |=> (!valid_o || wire_byte_o == CMD_AUTO_ADDR))
    else $error("stray byte after end of update");

  // busy only while a sequence is running
  a_busy_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> valid_o)
    else $error("busy without bytes being produced");

endmodule
